[rtl/lfb_pkg.sv]
package lfb_pkg;

	localparam int KIND_W     = 3;
	localparam int LEVEL_W    = 8;
	localparam int REPEAT_W   = 16;
	localparam int CMD_W      = 2;
	localparam int BRIGHT_W   = 8;
	localparam int STEP_W     = 8;
	localparam int INTERVAL_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [BRIGHT_W-1:0]   MAX_BRIGHT_RST  = 8'd255;
	localparam logic [STEP_W-1:0]     BRIGHT_STEP_RST = 8'd1;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RST    = 16'd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK       = 3'd0,
		KIND_LIGHT_UP   = 3'd1,
		KIND_TURN_OFF   = 3'd2,
		KIND_SET_BRIGHT = 3'd3,
		KIND_RUN        = 3'd4,
		KIND_RUN_UP     = 3'd5,
		KIND_RUN_DOWN   = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		MODE_FINISHED = 2'd0,
		MODE_RUN      = 2'd1,
		MODE_RUN_UP   = 2'd2,
		MODE_RUN_DOWN = 2'd3
	} mode_t;

	typedef enum logic [CMD_W-1:0] {
		PWM_NONE     = 2'd0,
		PWM_WRITE    = 2'd1,
		PWM_FULL_ON  = 2'd2,
		PWM_FULL_OFF = 2'd3
	} pwm_cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_BRIGHT  = 2'd0,
		CFG_BRIGHT_STEP = 2'd1,
		CFG_INTERVAL    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [BRIGHT_W-1:0]   max_bright;
		logic [STEP_W-1:0]     bright_step;
		logic [INTERVAL_W-1:0] interval_ms;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [LEVEL_W-1:0]  level;
		logic [REPEAT_W-1:0] repeat_count;
	} item_t;

	typedef struct packed {
		logic [CMD_W-1:0]    pwm_cmd;
		logic [BRIGHT_W-1:0] pwm_level;
		logic                busy_res;
	} result_t;

	// rem_idle stands for the "no run pending" value of the repetition counter
	typedef struct packed {
		mode_t                 mode;
		logic [BRIGHT_W-1:0]   bright;
		logic                  rising;
		logic                  rem_idle;
		logic [REPEAT_W-1:0]   remaining;
		logic [INTERVAL_W-1:0] elapsed;
	} seq_state_t;

endpackage

[rtl/lfb_cmd_if.sv]
interface lfb_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [lfb_pkg::KIND_W-1:0]     kind;
	logic [lfb_pkg::LEVEL_W-1:0]    level;
	logic [lfb_pkg::REPEAT_W-1:0]   repeat_count;

	modport source(output valid, kind, level, repeat_count, input ready);
	modport sink(input valid, kind, level, repeat_count, output ready);
endinterface

[rtl/lfb_res_if.sv]
interface lfb_res_if;
	logic                           valid;
	logic                           ready;
	logic [lfb_pkg::CMD_W-1:0]      pwm_cmd;
	logic [lfb_pkg::BRIGHT_W-1:0]   pwm_level;
	logic                           busy_res;

	modport source(output valid, pwm_cmd, pwm_level, busy_res, input ready);
	modport sink(input valid, pwm_cmd, pwm_level, busy_res, output ready);
endinterface

[rtl/lfb_cfg_if.sv]
interface lfb_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [lfb_pkg::CFG_IDX_W-1:0]   index;
	logic [lfb_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[rtl/lfb_cfg.sv]
module lfb_cfg (
	input  logic            clk,
	input  logic            arst_n,
	lfb_cfg_if.sink         cfg,
	output lfb_pkg::cfg_t   cfg_q
);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_bright  <= lfb_pkg::MAX_BRIGHT_RST;
			cfg_q.bright_step <= lfb_pkg::BRIGHT_STEP_RST;
			cfg_q.interval_ms <= lfb_pkg::INTERVAL_RST;
		end else if (cfg.valid) begin
			case (lfb_pkg::cfg_idx_t'(cfg.index))
				lfb_pkg::CFG_MAX_BRIGHT: begin
					cfg_q.max_bright <= cfg.data[lfb_pkg::BRIGHT_W-1:0];
				end
				lfb_pkg::CFG_BRIGHT_STEP: begin
					cfg_q.bright_step <= cfg.data[lfb_pkg::STEP_W-1:0];
				end
				lfb_pkg::CFG_INTERVAL: begin
					cfg_q.interval_ms <= cfg.data[lfb_pkg::INTERVAL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/lfb_step.sv]
module lfb_step (
	input  lfb_pkg::cfg_t       cfg,
	input  lfb_pkg::item_t      item,
	input  lfb_pkg::seq_state_t cur,
	output lfb_pkg::seq_state_t nxt,
	output lfb_pkg::result_t    res
);

	logic                                busy;
	logic [lfb_pkg::BRIGHT_W:0]          up_sum;
	logic                                up_hit;
	logic [lfb_pkg::BRIGHT_W:0]          dn_diff;
	logic                                dn_hit;
	logic [lfb_pkg::INTERVAL_W:0]        elapsed_inc;
	logic                                fire;
	logic [lfb_pkg::REPEAT_W-1:0]        rem_dec;
	lfb_pkg::seq_state_t                 stop_st;
	lfb_pkg::seq_state_t                 fin_st;

	assign busy        = (cur.mode != lfb_pkg::MODE_FINISHED);
	assign up_sum      = {1'b0, cur.bright} + {1'b0, cfg.bright_step};
	assign up_hit      = (up_sum >= {1'b0, cfg.max_bright});
	assign dn_diff     = {1'b0, cur.bright} - {1'b0, cfg.bright_step};
	assign dn_hit      = (cur.bright <= cfg.bright_step);
	assign elapsed_inc = {1'b0, cur.elapsed} + {{lfb_pkg::INTERVAL_W{1'b0}}, 1'b1};
	assign fire        = (elapsed_inc > {1'b0, cfg.interval_ms});
	assign rem_dec     = cur.remaining - {{(lfb_pkg::REPEAT_W-1){1'b0}}, 1'b1};

	always_comb begin
		stop_st           = cur;
		stop_st.mode      = lfb_pkg::MODE_FINISHED;
		stop_st.bright    = '0;
		stop_st.rising    = 1'b1;
		stop_st.rem_idle  = 1'b1;
		stop_st.remaining = '0;
		stop_st.elapsed   = cfg.interval_ms;
	end

	// graceful finish request on top of the current state
	always_comb begin
		fin_st = cur;
		case (cur.mode)
			lfb_pkg::MODE_RUN: begin
				if (!cur.rem_idle && cur.remaining > {{(lfb_pkg::REPEAT_W-1){1'b0}}, 1'b1})
					fin_st.remaining = {{(lfb_pkg::REPEAT_W-1){1'b0}}, 1'b1};
			end
			lfb_pkg::MODE_RUN_UP: begin
				if (cur.bright == cfg.max_bright)
					fin_st.mode = lfb_pkg::MODE_FINISHED;
			end
			lfb_pkg::MODE_RUN_DOWN: begin
				if (cur.bright == '0)
					fin_st.mode = lfb_pkg::MODE_FINISHED;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		nxt           = cur;
		res.pwm_cmd   = lfb_pkg::PWM_NONE;
		res.pwm_level = '0;
		res.busy_res  = busy;
		case (lfb_pkg::kind_t'(item.kind))
			lfb_pkg::KIND_TICK: begin
				if (!busy) begin
					nxt = stop_st;
				end else if (fire) begin
					nxt.elapsed = '0;
					if (cur.rising) begin
						if (up_hit) begin
							nxt.bright = cfg.max_bright;
							if (cur.mode == lfb_pkg::MODE_RUN)
								nxt.rising = 1'b0;
						end else begin
							nxt.bright = up_sum[lfb_pkg::BRIGHT_W-1:0];
						end
					end else begin
						if (dn_hit) begin
							nxt.bright = '0;
							if (cur.mode == lfb_pkg::MODE_RUN) begin
								nxt.rising = 1'b1;
								// endless run keeps the counter at zero
								if (!cur.rem_idle && cur.remaining != '0) begin
									nxt.remaining = rem_dec;
									if (rem_dec == '0)
										nxt = stop_st;
								end
							end
						end else begin
							nxt.bright = dn_diff[lfb_pkg::BRIGHT_W-1:0];
						end
					end
					res.pwm_cmd   = lfb_pkg::PWM_WRITE;
					res.pwm_level = nxt.bright;
				end else begin
					nxt.elapsed = elapsed_inc[lfb_pkg::INTERVAL_W-1:0];
				end
			end
			lfb_pkg::KIND_LIGHT_UP: begin
				nxt         = stop_st;
				res.pwm_cmd = lfb_pkg::PWM_FULL_ON;
			end
			lfb_pkg::KIND_TURN_OFF: begin
				nxt         = stop_st;
				res.pwm_cmd = lfb_pkg::PWM_FULL_OFF;
			end
			lfb_pkg::KIND_SET_BRIGHT: begin
				nxt           = stop_st;
				nxt.bright    = item.level;
				res.pwm_cmd   = lfb_pkg::PWM_WRITE;
				res.pwm_level = item.level;
			end
			lfb_pkg::KIND_RUN: begin
				if (busy) begin
					nxt = fin_st;
				end else if (cur.rem_idle) begin
					nxt.mode      = lfb_pkg::MODE_RUN;
					nxt.rem_idle  = 1'b0;
					nxt.remaining = item.repeat_count;
				end
			end
			lfb_pkg::KIND_RUN_UP: begin
				if (cur.bright < cfg.max_bright) begin
					if (busy) begin
						nxt = fin_st;
					end else begin
						nxt.rising = 1'b1;
						nxt.mode   = lfb_pkg::MODE_RUN_UP;
					end
				end
			end
			lfb_pkg::KIND_RUN_DOWN: begin
				if (cur.bright != '0) begin
					if (busy) begin
						nxt = fin_st;
					end else begin
						nxt.rising = 1'b0;
						nxt.mode   = lfb_pkg::MODE_RUN_DOWN;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/led_fade_blink_sequencer.sv]
// channel   modport  moves
// cmd_in    sink     item: kind, level, repeat_count
// res_out   source   item: pwm_cmd, pwm_level, busy_res
// cfg       sink     register write: index, data (always ready)
//
// One item per cycle sustained while res_out is not stalled; an accepted item goes
// into the input register, then the state and result registers take its step.
// Reset returns the registers to their defaults and the channel to finished.
// A stalled result holds the input register; cmd_in.ready drops only while
// both the input register and the result register are full.
module led_fade_blink_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	lfb_cmd_if.sink     cmd_in,
	lfb_res_if.source   res_out,
	lfb_cfg_if.sink     cfg
);

	lfb_pkg::cfg_t       cfg_q;
	lfb_pkg::item_t      item_s1;
	logic                valid_s1;
	lfb_pkg::result_t    res_s2;
	logic                valid_s2;
	lfb_pkg::seq_state_t state_q;
	lfb_pkg::seq_state_t state_nxt;
	lfb_pkg::result_t    res_nxt;
	logic                advance;
	logic                in_ready;

	lfb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	assign advance      = valid_s1 && (!valid_s2 || res_out.ready);
	assign in_ready     = !valid_s1 || advance;
	assign cmd_in.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= cmd_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && cmd_in.valid) begin
			item_s1.kind         <= cmd_in.kind;
			item_s1.level        <= cmd_in.level;
			item_s1.repeat_count <= cmd_in.repeat_count;
		end
	end

	lfb_step u_step (
		.cfg  (cfg_q),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode      <= lfb_pkg::MODE_FINISHED;
			state_q.bright    <= '0;
			state_q.rising    <= 1'b1;
			state_q.rem_idle  <= 1'b1;
			state_q.remaining <= '0;
			state_q.elapsed   <= lfb_pkg::INTERVAL_RST;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign res_out.valid     = valid_s2;
	assign res_out.pwm_cmd   = res_s2.pwm_cmd;
	assign res_out.pwm_level = res_s2.pwm_level;
	assign res_out.busy_res  = res_s2.busy_res;

endmodule

[rtl/lfb_checker.sv]
module lfb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [lfb_pkg::CMD_W-1:0]     out_cmd,
	input logic [lfb_pkg::BRIGHT_W-1:0]  out_level
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// level only carries data on a level write
	a_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_cmd != lfb_pkg::PWM_WRITE |-> out_level == '0)
		else $error("pwm_level nonzero without a level write");

	// a fresh result comes from an item taken in through the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching input item");

	// input side never stalls while the result register is empty
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

endmodule

bind led_fade_blink_sequencer lfb_checker u_lfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cmd_in.valid),
	.in_ready  (cmd_in.ready),
	.out_valid (res_out.valid),
	.out_ready (res_out.ready),
	.out_cmd   (res_out.pwm_cmd),
	.out_level (res_out.pwm_level)
);

[tb/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lfb_pkg::*;

	typedef struct {
		item_t cmd;
		int    gap;
	} queued_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lfb_cmd_if cmd_if();
	lfb_res_if res_if();
	lfb_cfg_if cfg_if();

	led_fade_blink_sequencer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_in  (cmd_if),
		.res_out (res_if),
		.cfg     (cfg_if)
	);

	always #4 clk = ~clk;

	// commands waiting to be offered, and pwm results still to arrive
	queued_cmd_t cmd_backlog[$];
	result_t     pwm_due[$];

	int items_sent = 0;
	int results_seen = 0;
	int errors = 0;
	int settings_used = 0;

	logic item_taken = 1'b0;
	logic res_taken = 1'b0;
	bit   send_calm = 1'b0;
	bit   recv_calm = 1'b0;
	int   recv_wait = 0;
	bit   hold_start = 1'b0;
	logic hold_recv = 1'b0;

	// stimulus-side view of the registers, used to size tick runs
	int cur_max = 255;
	int cur_step = 1;
	int cur_interval = 1;

	// predicted channel state and register copies
	mode_t st_mode = MODE_FINISHED;
	int    st_bright = 0;
	bit    st_rising = 1'b1;
	int    st_remaining = -1;
	int    st_elapsed = int'(INTERVAL_RST);
	int    rg_max = int'(MAX_BRIGHT_RST);
	int    rg_step = int'(BRIGHT_STEP_RST);
	int    rg_interval = int'(INTERVAL_RST);

	function automatic void stop_channel();
		st_remaining = -1;
		st_bright = 0;
		st_rising = 1'b1;
		st_mode = MODE_FINISHED;
		st_elapsed = rg_interval;
	endfunction

	// a start command seen while a ramp or blink is active
	function automatic bit finish_request();
		case (st_mode)
			MODE_RUN: begin
				if (st_remaining > 1)
					st_remaining = 1;
				return 1'b1;
			end
			MODE_RUN_UP: begin
				if (st_bright == rg_max)
					st_mode = MODE_FINISHED;
				return 1'b1;
			end
			MODE_RUN_DOWN: begin
				if (st_bright == 0)
					st_mode = MODE_FINISHED;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void ramp_step();
		if (st_rising) begin
			st_bright = st_bright + rg_step;
			if (st_bright >= rg_max) begin
				st_bright = rg_max;
				if (st_mode == MODE_RUN)
					st_rising = 1'b0;
			end
		end else begin
			st_bright = st_bright - rg_step;
			if (st_bright <= 0) begin
				st_bright = 0;
				if (st_mode == MODE_RUN) begin
					st_rising = 1'b1;
					// endless blink keeps remaining at zero
					if (st_remaining != 0) begin
						st_remaining = st_remaining - 1;
						if (st_remaining == 0)
							stop_channel();
					end
				end
			end
		end
	endfunction

	function automatic result_t next_pwm(item_t it);
		result_t r;
		bit      active;
		int      nxt;
		r = '0;
		active = (st_mode != MODE_FINISHED);
		case (it.kind)
			KIND_TICK: begin
				if (!active) begin
					stop_channel();
				end else begin
					nxt = st_elapsed + 1;
					if (nxt > rg_interval) begin
						st_elapsed = 0;
						ramp_step();
						r.pwm_cmd = PWM_WRITE;
						r.pwm_level = st_bright[7:0];
					end else begin
						st_elapsed = nxt & 16'hFFFF;
					end
				end
			end
			KIND_LIGHT_UP: begin
				stop_channel();
				r.pwm_cmd = PWM_FULL_ON;
			end
			KIND_TURN_OFF: begin
				stop_channel();
				r.pwm_cmd = PWM_FULL_OFF;
			end
			KIND_SET_BRIGHT: begin
				stop_channel();
				st_bright = int'(it.level);
				r.pwm_cmd = PWM_WRITE;
				r.pwm_level = it.level;
			end
			KIND_RUN: begin
				if (!finish_request() && st_remaining < 0) begin
					st_mode = MODE_RUN;
					st_remaining = int'(it.repeat_count);
				end
			end
			KIND_RUN_UP: begin
				if (st_bright < rg_max && !finish_request()) begin
					st_rising = 1'b1;
					st_mode = MODE_RUN_UP;
				end
			end
			KIND_RUN_DOWN: begin
				if (st_bright > 0 && !finish_request()) begin
					st_rising = 1'b0;
					st_mode = MODE_RUN_DOWN;
				end
			end
			default: ;
		endcase
		r.busy_res = active;
		return r;
	endfunction

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= 10)
			$display("ERROR: %s", msg);
	endfunction

	// acceptance: predict each item and track register writes
	always @(posedge clk) begin
		item_t it;
		item_taken <= cmd_if.valid && cmd_if.ready;
		if (cmd_if.valid && cmd_if.ready) begin
			it.kind = cmd_if.kind;
			it.level = cmd_if.level;
			it.repeat_count = cmd_if.repeat_count;
			pwm_due.push_back(next_pwm(it));
		end
		if (cfg_if.valid && cfg_if.ready) begin
			case (cfg_if.index)
				CFG_MAX_BRIGHT:  rg_max = int'(cfg_if.data[7:0]);
				CFG_BRIGHT_STEP: rg_step = int'(cfg_if.data[7:0]);
				CFG_INTERVAL:    rg_interval = int'(cfg_if.data);
				default: ;
			endcase
		end
	end

	// driver: each queued item carries the idle cycles to wait before it
	always @(negedge clk) begin
		queued_cmd_t q;
		if (!cmd_if.valid || item_taken) begin
			if (cmd_backlog.size() == 0) begin
				cmd_if.valid <= 1'b0;
			end else if (cmd_backlog[0].gap > 0) begin
				cmd_backlog[0].gap = cmd_backlog[0].gap - 1;
				cmd_if.valid <= 1'b0;
			end else begin
				q = cmd_backlog.pop_front();
				cmd_if.kind <= q.cmd.kind;
				cmd_if.level <= q.cmd.level;
				cmd_if.repeat_count <= q.cmd.repeat_count;
				cmd_if.valid <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t want;
		res_taken <= res_if.valid && res_if.ready;
		if (res_if.valid && res_if.ready) begin
			results_seen++;
			if (pwm_due.size() == 0) begin
				flag_error($sformatf("result with nothing pending: cmd %0d level %0d busy %0b",
					res_if.pwm_cmd, res_if.pwm_level, res_if.busy_res));
			end else begin
				want = pwm_due.pop_front();
				if (res_if.pwm_cmd !== want.pwm_cmd || res_if.pwm_level !== want.pwm_level ||
						res_if.busy_res !== want.busy_res)
					flag_error($sformatf(
						"result %0d: cmd %0d/%0d level %0d/%0d busy %0b/%0b (want/got)",
						results_seen, want.pwm_cmd, res_if.pwm_cmd, want.pwm_level,
						res_if.pwm_level, want.busy_res, res_if.busy_res));
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (res_taken) begin
			recv_wait = recv_calm ? 0 : $urandom_range(0, 4);
			if ($urandom_range(0, 39) == 0)
				recv_calm = !recv_calm;
		end
		if (hold_recv) begin
			res_if.ready <= 1'b0;
		end else if (recv_wait > 0) begin
			recv_wait--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	// long receiver hold-off so the block fills and stalls its input
	initial begin : recv_hold_off
		wait (hold_start);
		hold_recv <= 1'b1;
		repeat (300) @(negedge clk);
		hold_recv <= 1'b0;
	end

	initial begin : watchdog
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic push_cmd(logic [KIND_W-1:0] kind, logic [7:0] level, logic [15:0] reps);
		queued_cmd_t q;
		q.cmd.kind = kind;
		q.cmd.level = level;
		q.cmd.repeat_count = reps;
		q.gap = send_calm ? 0 : $urandom_range(0, 4);
		cmd_backlog.push_back(q);
		items_sent++;
	endtask

	task automatic push_tick();
		push_cmd(KIND_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
	endtask

	// every item gives one result, so equal counts mean the block is idle
	task automatic wait_drained();
		do
			@(negedge clk);
		while (results_seen != items_sent);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_if.index <= idx;
		cfg_if.data <= val;
		cfg_if.valid <= 1'b1;
		do
			@(posedge clk);
		while (cfg_if.ready !== 1'b1);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic set_config(int mx, int stp, int ivl);
		wait_drained();
		repeat (3) @(negedge clk);
		write_reg(CFG_MAX_BRIGHT, 16'(mx));
		write_reg(CFG_BRIGHT_STEP, 16'(stp));
		write_reg(CFG_INTERVAL, 16'(ivl));
		cur_max = mx;
		cur_step = stp;
		cur_interval = ivl;
		settings_used++;
	endtask

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'(cur_max);
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one well-formed sequence with random content, or a bit of noise
	task automatic run_scenario();
		int pick, reps, ticks, half, cut;
		pick = $urandom_range(0, 99);
		half = (cur_step == 0) ? 4 : (cur_max + cur_step - 1) / cur_step;
		if (half < 1)
			half = 1;
		if (pick < 45) begin
			case ($urandom_range(0, 3))
				0: push_cmd(KIND_SET_BRIGHT, pick_level(), 16'($urandom_range(0, 65535)));
				1: push_cmd(KIND_TURN_OFF, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
				2: push_tick();
				default: ;
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: reps = $urandom_range(1, 3);
				6, 7: reps = 0;
				default: reps = $urandom_range(0, 65535);
			endcase
			push_cmd(KIND_RUN, 8'($urandom_range(0, 255)), 16'(reps));
			ticks = (2 * half * ((reps >= 1 && reps <= 3) ? reps : 2) + 2) * (cur_interval + 1);
		end else if (pick < 70) begin
			push_cmd(KIND_SET_BRIGHT, pick_level(), 16'($urandom_range(0, 65535)));
			if ($urandom_range(0, 1) == 0)
				push_cmd(KIND_RUN_UP, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
			else
				push_cmd(KIND_RUN_DOWN, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
			ticks = (half + 2) * (cur_interval + 1);
		end else if (pick < 85) begin
			repeat ($urandom_range(1, 4))
				push_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
					16'($urandom_range(0, 65535)));
			ticks = 0;
		end else begin
			ticks = $urandom_range(1, 8);
		end
		if (ticks > 60)
			ticks = 60;
		// now and then a command lands in the middle of a ramp
		cut = (ticks > 0 && $urandom_range(0, 3) == 0) ? $urandom_range(0, ticks - 1) : -1;
		for (int i = 0; i < ticks; i++) begin
			if (i == cut)
				push_cmd(3'($urandom_range(1, 6)), pick_level(), 16'($urandom_range(0, 3)));
			push_tick();
		end
	endtask

	task automatic run_phase(int count);
		int  stop_at, mid;
		bit  paused;
		stop_at = items_sent + count;
		mid = items_sent + count / 2;
		paused = 1'b0;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 4) == 0)
				send_calm = !send_calm;
			run_scenario();
			if (!paused && items_sent >= mid) begin
				paused = 1'b1;
				wait_drained();
			end
		end
	endtask

	initial begin : stimulus
		int mx;
		cmd_if.valid = 1'b0;
		cmd_if.kind = '0;
		cmd_if.level = '0;
		cmd_if.repeat_count = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_MAX_BRIGHT;
		cfg_if.data = '0;
		res_if.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset register values
		push_cmd(KIND_TICK, 8'd255, 16'hFFFF);
		push_cmd(KIND_LIGHT_UP, 8'd0, 16'd0);
		push_cmd(KIND_TURN_OFF, 8'd255, 16'hFFFF);
		push_cmd(KIND_SET_BRIGHT, 8'd255, 16'd0);
		push_tick();                                   // idle tick clears stored level
		push_cmd(KIND_RUN_DOWN, 8'd0, 16'd0);          // refused at zero
		push_cmd(3'd7, 8'd255, 16'hFFFF);              // unused kind
		push_cmd(KIND_SET_BRIGHT, 8'd254, 16'd0);
		push_cmd(KIND_RUN_UP, 8'd0, 16'd0);
		push_tick();
		push_cmd(KIND_RUN_UP, 8'd0, 16'd0);            // refused at the top, the ramp stays active
		push_tick();
		push_cmd(KIND_SET_BRIGHT, 8'd255, 16'd0);
		push_cmd(KIND_RUN_UP, 8'd0, 16'd0);            // refused at the top
		push_cmd(KIND_SET_BRIGHT, 8'd1, 16'd0);
		push_cmd(KIND_RUN_DOWN, 8'd0, 16'd0);
		push_tick();
		push_cmd(KIND_RUN_DOWN, 8'd0, 16'd0);          // refused at zero, the ramp stays active
		push_cmd(KIND_RUN, 8'd0, 16'd0);               // finish request: ends the run-down at zero
		push_tick();
		push_cmd(KIND_RUN, 8'd0, 16'd0);               // starts an endless blink
		push_cmd(KIND_SET_BRIGHT, 8'd0, 16'd0);
		push_cmd(KIND_RUN, 8'd0, 16'hFFFF);
		push_cmd(KIND_RUN, 8'd0, 16'd5);               // cuts repetitions to one
		push_cmd(KIND_LIGHT_UP, 8'd0, 16'd0);

		set_config(255, 255, 0);
		run_phase(130);

		// one-step ramp: a single blink ends the run with a zero write
		set_config(1, 1, 0);
		push_cmd(KIND_TURN_OFF, 8'd0, 16'd0);
		push_cmd(KIND_RUN, 8'd0, 16'd1);
		push_tick();
		push_tick();
		push_tick();
		run_phase(130);

		set_config(100, 30, 2);
		hold_start = 1'b1;
		send_calm = 1'b1;
		run_phase(130);

		set_config(255, 64, 65535);
		run_phase(60);

		// out-of-range register values
		set_config(0, 0, 1);
		run_phase(40);

		repeat (4) begin
			mx = $urandom_range(1, 255);
			set_config(mx, $urandom_range(mx / 6 + 1, 255), $urandom_range(0, 3));
			run_phase(150);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (pwm_due.size() != 0)
			flag_error($sformatf("%0d results never arrived", pwm_due.size()));
		$display("checked %0d results from %0d items over %0d register settings",
			results_seen, items_sent, settings_used);
		$display("covered blink, ramp, finish requests, stalls and %0d error(s)", errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
